[rtl/core/assert_macros.svh]
// Assertion macros for the RTL of the box blur block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define RBB_ASSERT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define RBB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define RBB_ASSERT(label, clk, rst_n, ante, cons)
`define RBB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/rbb_pkg.sv]
// Types, constants and arithmetic helpers of the 3x3 RGB box blur.
`timescale 1ns / 1ps

package rbb_pkg;

	localparam int PIX_W        = 8;
	localparam int RGB_W        = 3 * PIX_W;
	localparam int VSUM_W       = 10;  // up to three pixels
	localparam int HSUM_W       = 12;  // up to nine pixels plus rounding bias
	localparam int WIDTH_REG_W  = 12;
	localparam int HEIGHT_REG_W = 13;
	localparam int CFG_DATA_W   = 13;

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

	// Reciprocals for the constant divides, exact for every sum that can occur.
	localparam int RECIP_W     = 13;
	localparam int RECIP_SHIFT = 15;
	localparam int MUL_W       = HSUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_6 = 13'd5462;
	localparam logic [RECIP_W-1:0] RECIP_9 = 13'd3641;

	typedef enum logic {
		CFG_IMAGE_WIDTH  = 1'b0,
		CFG_IMAGE_HEIGHT = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		DIV4 = 2'd0,
		DIV6 = 2'd1,
		DIV9 = 2'd2
	} div_t;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		pix_t r;
		pix_t g;
		pix_t b;
	} rgb_t;

	typedef struct packed {
		logic [VSUM_W-1:0] r;
		logic [VSUM_W-1:0] g;
		logic [VSUM_W-1:0] b;
	} vsum_t;

	typedef struct packed {
		logic [HSUM_W-1:0] r;
		logic [HSUM_W-1:0] g;
		logic [HSUM_W-1:0] b;
	} hsum_t;

	// Vertical sum of one column; the top pixel is dropped above the frame.
	function automatic vsum_t col_sum(input rgb_t top, input rgb_t mid, input rgb_t bot,
			input logic use_top);
		vsum_t s;
		s.r = VSUM_W'(mid.r) + VSUM_W'(bot.r) + (use_top ? VSUM_W'(top.r) : '0);
		s.g = VSUM_W'(mid.g) + VSUM_W'(bot.g) + (use_top ? VSUM_W'(top.g) : '0);
		s.b = VSUM_W'(mid.b) + VSUM_W'(bot.b) + (use_top ? VSUM_W'(top.b) : '0);
		return s;
	endfunction

	// Horizontal sum of column sums; c2 is dropped at the left and right edges.
	function automatic hsum_t row_sum(input vsum_t c0, input vsum_t c1, input vsum_t c2,
			input logic use_c2);
		hsum_t s;
		s.r = HSUM_W'(c0.r) + HSUM_W'(c1.r) + (use_c2 ? HSUM_W'(c2.r) : '0);
		s.g = HSUM_W'(c0.g) + HSUM_W'(c1.g) + (use_c2 ? HSUM_W'(c2.g) : '0);
		s.b = HSUM_W'(c0.b) + HSUM_W'(c1.b) + (use_c2 ? HSUM_W'(c2.b) : '0);
		return s;
	endfunction

	// Mean rounded half up: floor((sum + n/2) / n) for n of 4, 6 or 9.
	function automatic pix_t mean_round(input logic [HSUM_W-1:0] sum, input div_t d);
		logic [HSUM_W-1:0]  v;
		logic [RECIP_W-1:0] m;
		logic [MUL_W-1:0]   p;
		unique case (d)
			DIV4:    v = sum + 12'd2;
			DIV6:    v = sum + 12'd3;
			DIV9:    v = sum + 12'd4;
			default: v = sum;
		endcase
		m = (d == DIV9) ? RECIP_9 : RECIP_6;
		p = MUL_W'(v) * MUL_W'(m);
		if (d == DIV4) begin
			return v[PIX_W+1:2];
		end
		return p[RECIP_SHIFT+PIX_W-1:RECIP_SHIFT];
	endfunction

endpackage

[rtl/core/rbb_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module rbb_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 2048,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/rgb_box_blur_3x3.sv]
// Top level of the streaming 3x3 RGB box blur with edge-normalized means.
`timescale 1ns / 1ps

//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------------------
//  cfg     | in        | cfg_write           | cfg_index, cfg_data
//  in      | in        | in_valid / in_ready | red_in, green_in, blue_in
//  out     | out       | out_valid/out_ready | out_row, out_col, red/green/blue_out, run_end
//
//  A pixel enters every cycle while in_ready is high; the emit stage issues the results it
//  causes one at a time (none to two per pixel, four on the final pixel of the frame), so
//  the result port sets the pace. out_valid rises when a result moves from the last stage
//  into the output register. Reset sets 640x480 and clears position and valid state; line
//  stores are not cleared. A stalled out_ready backs up stage by stage until in_ready drops.

`include "assert_macros.svh"

module rgb_box_blur_3x3 #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096,
	localparam int COL_W = $clog2(MAX_WIDTH),
	localparam int ROW_W = $clog2(MAX_HEIGHT)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic                                cfg_index,
	input  logic [rbb_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [rbb_pkg::PIX_W-1:0]           red_in,
	input  logic [rbb_pkg::PIX_W-1:0]           green_in,
	input  logic [rbb_pkg::PIX_W-1:0]           blue_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ROW_W-1:0]                    out_row,
	output logic [COL_W-1:0]                    out_col,
	output logic [rbb_pkg::PIX_W-1:0]           red_out,
	output logic [rbb_pkg::PIX_W-1:0]           green_out,
	output logic [rbb_pkg::PIX_W-1:0]           blue_out,
	output logic                                run_end
);

	localparam int RAM_W = 2 * rbb_pkg::RGB_W;

	// configuration and position
	logic [rbb_pkg::WIDTH_REG_W-1:0]  width_q;
	logic [rbb_pkg::HEIGHT_REG_W-1:0] height_q;
	logic [ROW_W-1:0]                 row_q;
	logic [COL_W-1:0]                 col_q;
	logic [COL_W-1:0]                 last_col;
	logic [ROW_W-1:0]                 last_row;
	logic                             in_accept;
	logic [3:0]                       res_new;

	// stage 1: pixel waiting for its line store read
	logic                 v_s1;
	rbb_pkg::rgb_t        px_s1;
	logic [ROW_W-1:0]     row_s1;
	logic [COL_W-1:0]     col_s1;
	logic                 r_ge2_s1;
	logic                 c_ge2_s1;
	logic [3:0]           res_s1;
	logic                 s1_adv;
	logic [RAM_W-1:0]     ram_rdata;
	rbb_pkg::rgb_t        older_px;
	rbb_pkg::rgb_t        prior_px;
	rbb_pkg::vsum_t       va_new;
	rbb_pkg::vsum_t       vb_new;

	// stage 2: column sums of columns c, c-1, c-2 and the results still owed
	logic                 v_s2;
	rbb_pkg::vsum_t       va0_s2, va1_s2, va2_s2;
	rbb_pkg::vsum_t       vb0_s2, vb1_s2, vb2_s2;
	logic [ROW_W-1:0]     row_s2;
	logic [COL_W-1:0]     col_s2;
	logic                 r_ge2_s2;
	logic                 c_ge2_s2;
	logic [3:0]           pend_s2;
	logic [3:0]           pick;
	logic [3:0]           rest;
	logic                 use_a;
	logic                 use_m2;
	logic                 emit;
	logic                 s2_last;
	logic                 s2_free;
	rbb_pkg::hsum_t       sum_sel;
	rbb_pkg::div_t        div_sel;

	// stage 3: one result's sums awaiting the divide
	logic                 v_s3;
	rbb_pkg::hsum_t       sum_s3;
	rbb_pkg::div_t        div_s3;
	logic [ROW_W-1:0]     row_s3;
	logic [COL_W-1:0]     col_s3;
	logic                 end_s3;
	logic                 s3_go;
	logic                 s3_free;

	// output register
	logic                 out_valid_q;
	logic [ROW_W-1:0]     row_s4;
	logic [COL_W-1:0]     col_s4;
	rbb_pkg::rgb_t        px_s4;
	logic                 end_s4;
	logic                 out_free;

	// ---------------------------------------------------------------- handshake
	assign out_free  = !out_valid_q || out_ready;
	assign s3_go     = v_s3 && out_free;
	assign s3_free   = !v_s3 || out_free;
	assign emit      = v_s2 && (pend_s2 != 4'd0) && s3_free;
	assign s2_last   = v_s2 && ((pend_s2 == 4'd0) || (s3_free && (rest == 4'd0)));
	assign s2_free   = !v_s2 || s2_last;
	assign s1_adv    = v_s1 && s2_free;
	assign in_ready  = !v_s1 || s1_adv;
	assign in_accept = in_valid && in_ready;

	// ---------------------------------------------------------------- frame geometry
	always_comb begin
		priority if (width_q < 12'd2) begin
			last_col = COL_W'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			last_col = COL_W'(MAX_WIDTH - 1);
		end else begin
			last_col = COL_W'(width_q - 12'd1);
		end
	end

	always_comb begin
		priority if (height_q < 13'd2) begin
			last_row = ROW_W'(1);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			last_row = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			last_row = ROW_W'(height_q - 13'd1);
		end
	end

	// results caused by the pixel at (row_q, col_q), in emit order from bit 0
	always_comb begin
		res_new[0] = (row_q != '0) && (col_q != '0);
		res_new[1] = (row_q != '0) && (col_q == last_col);
		res_new[2] = (row_q == last_row) && (col_q != '0);
		res_new[3] = (row_q == last_row) && (col_q == last_col);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rbb_pkg::WIDTH_RESET;
			height_q <= rbb_pkg::HEIGHT_RESET;
			row_q    <= '0;
			col_q    <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				rbb_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data[rbb_pkg::WIDTH_REG_W-1:0];
				rbb_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data;
			endcase
			// restart the frame
			row_q <= '0;
			col_q <= '0;
		end else if (in_accept) begin
			if (col_q == last_col) begin
				col_q <= '0;
				row_q <= (row_q == last_row) ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// ---------------------------------------------------------------- stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_accept) begin
			v_s1 <= 1'b1;
		end else if (s1_adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			px_s1    <= '{r: red_in, g: green_in, b: blue_in};
			row_s1   <= row_q;
			col_s1   <= col_q;
			r_ge2_s1 <= row_q > ROW_W'(1);
			c_ge2_s1 <= col_q > COL_W'(1);
			res_s1   <= res_new;
		end
	end

	// one entry per column holds rows r-2 and r-1; shift the column down on write
	rbb_ram #(
		.WIDTH (RAM_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (col_s1),
		.wdata ({prior_px, px_s1}),
		.re    (in_accept),
		.raddr (col_q),
		.rdata (ram_rdata)
	);

	assign older_px = ram_rdata[RAM_W-1:rbb_pkg::RGB_W];
	assign prior_px = ram_rdata[rbb_pkg::RGB_W-1:0];
	assign va_new   = rbb_pkg::col_sum(older_px, prior_px, px_s1, r_ge2_s1);
	assign vb_new   = rbb_pkg::col_sum(older_px, prior_px, px_s1, 1'b0);

	// ---------------------------------------------------------------- stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			pend_s2 <= '0;
		end else if (s1_adv) begin
			v_s2    <= 1'b1;
			pend_s2 <= res_s1;
		end else begin
			if (s2_last) begin
				v_s2 <= 1'b0;
			end
			if (emit) begin
				pend_s2 <= rest;
			end
		end
	end

	// column sums shift through as a window: index 0 is column c
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			va0_s2   <= va_new;
			va1_s2   <= va0_s2;
			va2_s2   <= va1_s2;
			vb0_s2   <= vb_new;
			vb1_s2   <= vb0_s2;
			vb2_s2   <= vb1_s2;
			row_s2   <= row_s1;
			col_s2   <= col_s1;
			r_ge2_s2 <= r_ge2_s1;
			c_ge2_s2 <= c_ge2_s1;
		end
	end

	// take the lowest owed result
	always_comb begin
		pick   = pend_s2 & (~pend_s2 + 4'd1);
		rest   = pend_s2 & ~pick;
		use_a  = pick[0] || pick[1];
		use_m2 = (pick[0] || pick[2]) && c_ge2_s2;
		if (use_a) begin
			sum_sel = rbb_pkg::row_sum(va0_s2, va1_s2, va2_s2, use_m2);
		end else begin
			sum_sel = rbb_pkg::row_sum(vb0_s2, vb1_s2, vb2_s2, use_m2);
		end
		priority if (use_a && r_ge2_s2 && use_m2) begin
			div_sel = rbb_pkg::DIV9;
		end else if ((use_a && r_ge2_s2) || use_m2) begin
			div_sel = rbb_pkg::DIV6;
		end else begin
			div_sel = rbb_pkg::DIV4;
		end
	end

	// ---------------------------------------------------------------- stage 3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (emit) begin
			v_s3 <= 1'b1;
		end else if (s3_go) begin
			v_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			sum_s3 <= sum_sel;
			div_s3 <= div_sel;
			row_s3 <= use_a ? row_s2 - ROW_W'(1) : row_s2;
			col_s3 <= (pick[0] || pick[2]) ? col_s2 - COL_W'(1) : col_s2;
			end_s3 <= (rest == 4'd0);
		end
	end

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s3_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_go) begin
			row_s4  <= row_s3;
			col_s4  <= col_s3;
			px_s4.r <= rbb_pkg::mean_round(sum_s3.r, div_s3);
			px_s4.g <= rbb_pkg::mean_round(sum_s3.g, div_s3);
			px_s4.b <= rbb_pkg::mean_round(sum_s3.b, div_s3);
			end_s4  <= end_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign out_row   = row_s4;
	assign out_col   = col_s4;
	assign red_out   = px_s4.r;
	assign green_out = px_s4.g;
	assign blue_out  = px_s4.b;
	assign run_end   = end_s4;

	// ---------------------------------------------------------------- assertions
	`RBB_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, in_accept, v_s1)
	`RBB_ASSERT_NEXT(a_item_held_while_owed, clk, arst_n, emit && (rest != 4'd0), v_s2)
	`RBB_ASSERT(a_corner_owes_all, clk, arst_n, v_s1 && res_s1[3], res_s1[2] && res_s1[1] && res_s1[0])
	`RBB_ASSERT_NEXT(a_emit_loads_s3, clk, arst_n, emit, v_s3)

endmodule

[tb/tb_rgb_box_blur_3x3.sv]
// Self-checking testbench for the streaming 3x3 RGB box blur: directed table, random frames.
`timescale 1ns / 1ps

module tb_rgb_box_blur_3x3;

	localparam int MAX_W         = 2048;
	localparam int MAX_H         = 4096;
	localparam int RAND_ITEMS    = 220;
	localparam int CALM_AFTER    = 180;
	localparam int SETTLE_CYCLES = 12;
	localparam int CYCLE_LIMIT   = 400000;

	typedef enum logic {
		STIM_CFG,
		STIM_PIX
	} stim_kind_t;

	typedef struct packed {
		stim_kind_t        kind;
		rbb_pkg::cfg_idx_t idx;
		logic [12:0]       data;
		rbb_pkg::rgb_t     px;
		logic [2:0]        typed_cnt;  // nonzero: results come from FLAT_RESULTS
	} stim_row_t;

	typedef struct packed {
		logic [11:0]   row;
		logic [10:0]   col;
		rbb_pkg::rgb_t px;
		logic          last;
	} blur_res_t;

	// Flat 2x2 frames: every mean equals the pixel value.
	localparam blur_res_t FLAT_RESULTS [8] = '{
		'{12'd0, 11'd0, 24'hFFFFFF, 1'b0},
		'{12'd0, 11'd1, 24'hFFFFFF, 1'b0},
		'{12'd1, 11'd0, 24'hFFFFFF, 1'b0},
		'{12'd1, 11'd1, 24'hFFFFFF, 1'b1},
		'{12'd0, 11'd0, 24'h000000, 1'b0},
		'{12'd0, 11'd1, 24'h000000, 1'b0},
		'{12'd1, 11'd0, 24'h000000, 1'b0},
		'{12'd1, 11'd1, 24'h000000, 1'b1}
	};

	localparam stim_row_t DIRECTED_TAB [31] = '{
		'{STIM_PIX, rbb_pkg::CFG_IMAGE_WIDTH,  13'd0,    24'hA55AFF, 3'd0},
		'{STIM_CFG, rbb_pkg::CFG_IMAGE_WIDTH,  13'd2,    24'h000000, 3'd0},
		'{STIM_CFG, rbb_pkg::CFG_IMAGE_HEIGHT, 13'd2,    24'h000000, 3'd0},
		'{STIM_PIX, rbb_pkg::CFG_IMAGE_WIDTH,  13'd0,    24'hFFFFFF, 3'd0},
		'{STIM_PIX, rbb_pkg::CFG_IMAGE_WIDTH,  13'd0,    24'hFFFFFF, 3'd0},
		'{STIM_PIX, rbb_pkg::CFG_IMAGE_WIDTH,  13'd0,    24'hFFFFFF, 3'd0},
		'{STIM_PIX, rbb_pkg::CFG_IMAGE_WIDTH,  13'd0,    24'hFFFFFF, 3'd4},
		'{STIM_PIX, rbb_pkg::CFG_IMAGE_WIDTH,  13'd0,    24'h000000, 3'd0},
		'{STIM_PIX, rbb_pkg::CFG_IMAGE_WIDTH,  13'd0,    24'h000000, 3'd0},
		'{STIM_PIX, rbb_pkg::CFG_IMAGE_WIDTH,  13'd0,    24'h000000, 3'd0},
		'{STIM_PIX, rbb_pkg::CFG_IMAGE_WIDTH,  13'd0,    24'h000000, 3'd4},
		'{STIM_CFG, rbb_pkg::CFG_IMAGE_WIDTH,  13'd0,    24'h000000, 3'd0},
		'{STIM_CFG, rbb_pkg::CFG_IMAGE_HEIGHT, 13'd1,    24'h000000, 3'd0},
		'{STIM_PIX, rbb_pkg::CFG_IMAGE_WIDTH,  13'd0,    24'hFF00FF, 3'd0},
		'{STIM_PIX, rbb_pkg::CFG_IMAGE_WIDTH,  13'd0,    24'h00FF00, 3'd0},
		'{STIM_PIX, rbb_pkg::CFG_IMAGE_WIDTH,  13'd0,    24'hFFFF00, 3'd0},
		'{STIM_PIX, rbb_pkg::CFG_IMAGE_WIDTH,  13'd0,    24'h0000FF, 3'd0},
		'{STIM_CFG, rbb_pkg::CFG_IMAGE_WIDTH,  13'h1FFF, 24'h000000, 3'd0},
		'{STIM_CFG, rbb_pkg::CFG_IMAGE_HEIGHT, 13'h1FFF, 24'h000000, 3'd0},
		'{STIM_PIX, rbb_pkg::CFG_IMAGE_WIDTH,  13'd0,    24'h123456, 3'd0},
		'{STIM_CFG, rbb_pkg::CFG_IMAGE_WIDTH,  13'd3,    24'h000000, 3'd0},
		'{STIM_CFG, rbb_pkg::CFG_IMAGE_HEIGHT, 13'd3,    24'h000000, 3'd0},
		'{STIM_PIX, rbb_pkg::CFG_IMAGE_WIDTH,  13'd0,    24'h0180FE, 3'd0},
		'{STIM_PIX, rbb_pkg::CFG_IMAGE_WIDTH,  13'd0,    24'h027FFD, 3'd0},
		'{STIM_PIX, rbb_pkg::CFG_IMAGE_WIDTH,  13'd0,    24'h102030, 3'd0},
		'{STIM_PIX, rbb_pkg::CFG_IMAGE_WIDTH,  13'd0,    24'hFF0080, 3'd0},
		'{STIM_PIX, rbb_pkg::CFG_IMAGE_WIDTH,  13'd0,    24'h030303, 3'd0},
		'{STIM_PIX, rbb_pkg::CFG_IMAGE_WIDTH,  13'd0,    24'hFEFF01, 3'd0},
		'{STIM_PIX, rbb_pkg::CFG_IMAGE_WIDTH,  13'd0,    24'h808080, 3'd0},
		'{STIM_PIX, rbb_pkg::CFG_IMAGE_WIDTH,  13'd0,    24'h40C000, 3'd0},
		'{STIM_PIX, rbb_pkg::CFG_IMAGE_WIDTH,  13'd0,    24'h070809, 3'd0}
	};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_write;
	rbb_pkg::cfg_idx_t cfg_index;
	logic [12:0]       cfg_data;
	logic              in_valid;
	logic              in_ready;
	logic [7:0]        red_in;
	logic [7:0]        green_in;
	logic [7:0]        blue_in;
	logic              out_valid;
	logic              out_ready;
	logic [11:0]       out_row;
	logic [10:0]       out_col;
	logic [7:0]        red_out;
	logic [7:0]        green_out;
	logic [7:0]        blue_out;
	logic              run_end;

	// Predictor state
	rbb_pkg::rgb_t     older_line [MAX_W];
	rbb_pkg::rgb_t     prior_line [MAX_W];
	rbb_pkg::rgb_t     win_cols [6];
	rbb_pkg::rgb_t     win_grid [3][3];
	int                next_row = 0;
	int                next_col = 0;
	logic [11:0]       width_reg = rbb_pkg::WIDTH_RESET;
	logic [12:0]       height_reg = rbb_pkg::HEIGHT_RESET;

	blur_res_t         blur_exp_q [$];
	int                typed_ptr = 0;
	int                err_count = 0;
	int                cycle_count = 0;
	int                gap_pct = 30;
	bit                calm = 1'b0;

	always #5 clk = ~clk;

	rgb_box_blur_3x3 DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_row   (out_row),
		.out_col   (out_col),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.run_end   (run_end)
	);

	task automatic log_error(string msg);
		$display("ERROR @%0t: %s", $time, msg);
		err_count++;
	endtask

	function automatic int clamp_dim(int v, int hi);
		if (v < 2) return 2;
		if (v > hi) return hi;
		return v;
	endfunction

	// Rounded mean of the in-bounds neighbours around grid (cr, cc), image (row, col).
	function automatic blur_res_t blur_at(int cr, int cc, int row, int col, int w, int h);
		int        sr;
		int        sg;
		int        sb;
		int        n;
		int        gr;
		int        gc;
		blur_res_t res;
		sr = 0;
		sg = 0;
		sb = 0;
		n = 0;
		for (int dr = -1; dr <= 1; dr++) begin
			gr = cr + dr;
			if (row + dr < 0 || row + dr > h - 1 || gr < 0 || gr > 2)
				continue;
			for (int dc = -1; dc <= 1; dc++) begin
				gc = cc + dc;
				if (col + dc < 0 || col + dc > w - 1 || gc < 0 || gc > 2)
					continue;
				sr += win_grid[gr][gc].r;
				sg += win_grid[gr][gc].g;
				sb += win_grid[gr][gc].b;
				n++;
			end
		end
		res.row  = 12'(row);
		res.col  = 11'(col);
		res.px.r = 8'((2 * sr + n) / (2 * n));
		res.px.g = 8'((2 * sg + n) / (2 * n));
		res.px.b = 8'((2 * sb + n) / (2 * n));
		res.last = 1'b0;
		return res;
	endfunction

	// Advance the predictor by one accepted pixel and queue what it completes.
	task automatic blur_predict(rbb_pkg::rgb_t px, int typed_cnt);
		int        w;
		int        h;
		int        r;
		int        c;
		int        n;
		blur_res_t res [4];
		w = clamp_dim(int'(width_reg), MAX_W);
		h = clamp_dim(int'(height_reg), MAX_H);
		if (next_row >= h || next_col >= w) begin
			next_row = 0;
			next_col = 0;
		end
		r = next_row;
		c = next_col;
		for (int i = 0; i < 3; i++) begin
			win_grid[i][0] = win_cols[3 + i];
			win_grid[i][1] = win_cols[i];
		end
		win_grid[0][2] = older_line[c];
		win_grid[1][2] = prior_line[c];
		win_grid[2][2] = px;

		n = 0;
		if (r >= 1 && c >= 1) begin
			res[n] = blur_at(1, 1, r - 1, c - 1, w, h);
			n = n + 1;
		end
		if (r >= 1 && c == w - 1) begin
			res[n] = blur_at(1, 2, r - 1, c, w, h);
			n = n + 1;
		end
		if (r == h - 1 && c >= 1) begin
			res[n] = blur_at(2, 1, r, c - 1, w, h);
			n = n + 1;
		end
		if (r == h - 1 && c == w - 1) begin
			res[n] = blur_at(2, 2, r, c, w, h);
			n = n + 1;
		end
		if (n > 0)
			res[n - 1].last = 1'b1;

		if (typed_cnt != 0) begin
			for (int i = 0; i < typed_cnt; i++) begin
				blur_exp_q.push_back(FLAT_RESULTS[typed_ptr]);
				typed_ptr = typed_ptr + 1;
			end
		end else begin
			for (int i = 0; i < n; i++)
				blur_exp_q.push_back(res[i]);
		end

		older_line[c] = win_grid[1][2];
		prior_line[c] = px;
		for (int i = 0; i < 3; i++) begin
			win_cols[3 + i] = win_grid[i][1];
			win_cols[i] = win_grid[i][2];
		end
		if (c + 1 >= w) begin
			next_col = 0;
			next_row = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			next_col = c + 1;
		end
	endtask

	// Hold the pixel until the transaction completes, with an optional gap before it.
	task automatic send_pixel(rbb_pkg::rgb_t px, int typed_cnt);
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat ($urandom_range(0, 14)) @(negedge clk);
		end
		@(negedge clk);
		in_valid = 1'b1;
		red_in   = px.r;
		green_in = px.g;
		blue_in  = px.b;
		do @(posedge clk); while (!in_ready);
		blur_predict(px, typed_cnt);
	endtask

	// Drop valid, drain every expected result, then let the pipeline empty.
	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (blur_exp_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_dim(rbb_pkg::cfg_idx_t idx, logic [12:0] val);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		if (idx == rbb_pkg::CFG_IMAGE_WIDTH)
			width_reg = val[11:0];
		else
			height_reg = val;
		next_row = 0;
		next_col = 0;
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	always @(posedge clk) begin : check_results
		blur_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (blur_exp_q.size() == 0) begin
				log_error($sformatf("unexpected result at (%0d,%0d)", out_row, out_col));
			end else begin
				want = blur_exp_q.pop_front();
				if (out_row !== want.row)
					log_error($sformatf("row: got %0d want %0d", out_row, want.row));
				if (out_col !== want.col)
					log_error($sformatf("col at row %0d: got %0d want %0d",
						want.row, out_col, want.col));
				if (red_out !== want.px.r)
					log_error($sformatf("red at (%0d,%0d): got %0d want %0d",
						want.row, want.col, red_out, want.px.r));
				if (green_out !== want.px.g)
					log_error($sformatf("green at (%0d,%0d): got %0d want %0d",
						want.row, want.col, green_out, want.px.g));
				if (blue_out !== want.px.b)
					log_error($sformatf("blue at (%0d,%0d): got %0d want %0d",
						want.row, want.col, blue_out, want.px.b));
				if (run_end !== want.last)
					log_error($sformatf("run_end at (%0d,%0d): got %0b want %0b",
						want.row, want.col, run_end, want.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				blur_exp_q.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// Result side: random stall bursts, none once the run goes calm.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(0, 14)) @(negedge clk);
			end else begin
				out_ready = 1'b1;
				repeat ($urandom_range(0, 19)) @(negedge clk);
			end
		end
	end

	initial begin
		int            row_i;
		int            k;
		int            npix;
		int            mode;
		int            w;
		int            h;
		int            rand_items;
		logic [12:0]   wcode;
		logic [12:0]   hcode;
		rbb_pkg::rgb_t px;

		arst_n    = 1'b0;
		cfg_write = 1'b0;
		cfg_index = rbb_pkg::CFG_IMAGE_WIDTH;
		cfg_data  = '0;
		in_valid  = 1'b0;
		red_in    = '0;
		green_in  = '0;
		blue_in   = '0;
		for (int i = 0; i < MAX_W; i++) begin
			older_line[i] = '0;
			prior_line[i] = '0;
		end
		for (int i = 0; i < 6; i++)
			win_cols[i] = '0;
		rand_items = 0;

		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		for (row_i = 0; row_i < $size(DIRECTED_TAB); row_i++) begin
			if (DIRECTED_TAB[row_i].kind == STIM_CFG) begin
				wait_idle();
				write_dim(DIRECTED_TAB[row_i].idx, DIRECTED_TAB[row_i].data);
			end else begin
				send_pixel(DIRECTED_TAB[row_i].px, int'(DIRECTED_TAB[row_i].typed_cnt));
			end
		end

		while (rand_items < RAND_ITEMS) begin
			wait_idle();
			calm = (rand_items >= CALM_AFTER);
			case ($urandom_range(0, 2))
				0: gap_pct = 0;
				1: gap_pct = 25;
				default: gap_pct = 50;
			endcase
			mode = $urandom_range(0, 9);
			w = $urandom_range(2, 8);
			h = $urandom_range(2, 6);
			if (mode < 6) begin
				npix = w * h * $urandom_range(1, 2);
			end else if (mode == 6) begin
				w = $urandom_range(16, 40);
				h = 2;
				npix = w * h;
			end else if (mode < 9) begin
				// cut the frame short; the next write restarts it
				npix = $urandom_range(1, w * h - 1);
			end else begin
				npix = $urandom_range(1, 12);
			end
			wcode = 13'(w);
			hcode = 13'(h);
			if (mode == 9) begin
				wcode = 13'($urandom);
				hcode = 13'($urandom);
			end else begin
				if (w == 2 && $urandom_range(0, 1) == 1)
					wcode = 13'($urandom_range(0, 1));
				if (h == 2 && $urandom_range(0, 1) == 1)
					hcode = 13'($urandom_range(0, 1));
			end
			write_dim(rbb_pkg::CFG_IMAGE_WIDTH, wcode);
			write_dim(rbb_pkg::CFG_IMAGE_HEIGHT, hcode);
			for (k = 0; k < npix; k++) begin
				case ($urandom_range(0, 9))
					0: px = '0;
					1: px = '1;
					default: px = 24'($urandom);
				endcase
				send_pixel(px, 0);
				rand_items++;
			end
		end

		wait_idle();
		if (err_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/rbb_pkg.sv
rtl/core/rbb_ram.sv
rtl/core/rgb_box_blur_3x3.sv
tb/tb_rgb_box_blur_3x3.sv
